// ===== hw/rtl/vrs_pkg.sv =====
// ----------------------------------------------------------------------------
// vrs_pkg: shared constants for the vertex relabel shuffle block
// Table geometry, generator constants, register indexes and command codes.
// ----------------------------------------------------------------------------
package vrs_pkg;

  localparam int unsigned AddrBits = 16;
  localparam int unsigned VertexW  = 16;
  localparam int unsigned ScaleW   = 5;
  localparam int unsigned SeedW    = 32;
  localparam int unsigned GenW     = 64;
  localparam int unsigned HalfW    = 32;

  localparam logic [GenW-1:0]  LcgMul = 64'd1365781351523;
  localparam logic [GenW-1:0]  LcgAdd = 64'd12345;
  localparam logic [HalfW-1:0] MulLo  = LcgMul[31:0];
  localparam logic [HalfW-1:0] MulHi  = LcgMul[63:32];

  localparam logic [ScaleW-1:0] ScaleReset = 5'd16;
  localparam logic [SeedW-1:0]  SeedReset  = 32'd4791;
  localparam logic [GenW-1:0]   GenReset   = 64'd1;

  // configuration register indexes
  localparam logic CfgScale = 1'b0;
  localparam logic CfgSeed  = 1'b1;

  // command codes
  localparam logic CmdBuild   = 1'b0;
  localparam logic CmdRelabel = 1'b1;

endpackage

// ===== hw/rtl/vertex_relabel_shuffle_top.sv =====
// ----------------------------------------------------------------------------
// vertex_relabel_shuffle_top: random vertex permutation table and lookup
// Builds a shuffled label table from a 64-bit LCG and maps vertex pairs.
// ----------------------------------------------------------------------------
// A relabel item reads both vertex ids from the label memory at once on its
// two read ports into the read registers; S_LOOKUP then moves the result into
// the output register once that is free, and the next item is taken only after
// that move, so a new relabel is not accepted while the last one is in flight.
// A build item fills 2^scale entries (scale clamped to 1..16) at one per cycle,
// then performs 2^scale swaps, each through S_MUL0..S_MUL3, S_RD, S_WR1, S_WR2:
// three passes through the shared 32x32 multiplier and a final add per
// generator step, one paired read, and two writes on the single write port.
// A build waits in S_DONE while the previous result still sits in the output
// register, and no input is taken during the whole build. The memory has no
// clearing pass: until the first build, relabel results read as zero.
module vertex_relabel_shuffle_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [vrs_pkg::SeedW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [vrs_pkg::VertexW-1:0]  vertex_a_i,
  input  logic [vrs_pkg::VertexW-1:0]  vertex_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vrs_pkg::VertexW-1:0]  label_a_o,
  output logic [vrs_pkg::VertexW-1:0]  label_b_o,
  output logic                         build_done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_FILL,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_RD,
    S_WR1,
    S_WR2,
    S_DONE
  } state_e;

  localparam int unsigned AW = vrs_pkg::AddrBits;
  localparam int unsigned SW = vrs_pkg::ScaleW;
  localparam int unsigned HW = vrs_pkg::HalfW;
  localparam int unsigned GW = vrs_pkg::GenW;

  state_e                      state_q;
  logic [SW-1:0]               scale_q;
  logic [vrs_pkg::SeedW-1:0]   seed_q;
  logic [GW-1:0]               gen_q;
  logic [AW-1:0]               idx_q;
  logic [AW-1:0]               build_mask_q;
  logic [AW-1:0]               built_mask_q;
  logic [SW-1:0]               shamt_q;
  logic                        built_q;
  logic                        out_valid_q;
  logic [vrs_pkg::VertexW-1:0] out_a_q;
  logic [vrs_pkg::VertexW-1:0] out_b_q;
  logic                        out_done_q;

  logic [2*HW-1:0]             prod_q;
  logic [GW-1:0]               acc_q;
  logic [AW-1:0]               jdx_q;

  logic [AW-1:0]               lbl_mem [2**AW];
  logic [AW-1:0]               rd_a_q;
  logic [AW-1:0]               rd_b_q;

  logic [SW-1:0]               eff_scale;
  logic [AW:0]                 size_full;
  logic [AW-1:0]               mask_d;
  logic [HW-1:0]               op_a;
  logic [HW-1:0]               op_b;
  logic [HW-1:0]               gen_hi_d;
  logic [30:0]                 draw;
  logic [AW-1:0]               jdx_d;
  logic                        in_xfer;
  logic                        out_free;
  logic                        out_load;
  logic                        mem_re;
  logic                        mem_we;
  logic [AW-1:0]               raddr_a;
  logic [AW-1:0]               raddr_b;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               wdata;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_load     = out_free && ((state_q == S_LOOKUP) || (state_q == S_DONE));
  assign out_valid_o  = out_valid_q;
  assign label_a_o    = out_a_q;
  assign label_b_o    = out_b_q;
  assign build_done_o = out_done_q;

  always_comb begin
    eff_scale = scale_q;
    if (scale_q == '0) begin
      eff_scale = SW'(1);
    end else if (scale_q > SW'(AW)) begin
      eff_scale = SW'(AW);
    end
  end

  assign size_full = (AW + 1)'(1) << eff_scale;
  assign mask_d    = AW'(size_full - (AW + 1)'(1));

  // generator step: g0*m0 + LcgAdd + ((g1*m0 + g0*m1) << 32), one product per cycle
  always_comb begin
    op_a = gen_q[HW-1:0];
    op_b = vrs_pkg::MulHi;
    case (state_q)
      S_MUL0: begin
        op_a = gen_q[HW-1:0];
        op_b = vrs_pkg::MulLo;
      end
      S_MUL1: begin
        op_a = gen_q[GW-1:HW];
        op_b = vrs_pkg::MulLo;
      end
      default: begin
        op_a = gen_q[HW-1:0];
        op_b = vrs_pkg::MulHi;
      end
    endcase
  end

  assign gen_hi_d = acc_q[GW-1:HW] + prod_q[HW-1:0];
  assign draw     = gen_hi_d[30:0];
  assign jdx_d    = AW'(draw >> shamt_q);

  always_comb begin
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    raddr_a = AW'(vertex_a_i) & built_mask_q;
    raddr_b = AW'(vertex_b_i) & built_mask_q;
    waddr   = idx_q;
    wdata   = idx_q;
    case (state_q)
      S_IDLE: begin
        mem_re = in_xfer && (command_i == vrs_pkg::CmdRelabel);
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_RD: begin
        mem_re  = 1'b1;
        raddr_a = idx_q;
        raddr_b = jdx_q;
      end
      S_WR1: begin
        mem_we = 1'b1;
        wdata  = rd_b_q;
      end
      S_WR2: begin
        mem_we = 1'b1;
        waddr  = jdx_q;
        wdata  = rd_a_q;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lbl_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_a_q <= lbl_mem[raddr_a];
      rd_b_q <= lbl_mem[raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    case (state_q)
      S_MUL1:  acc_q <= prod_q + vrs_pkg::LcgAdd;
      S_MUL2:  acc_q[GW-1:HW] <= gen_hi_d;
      S_MUL3:  jdx_q <= jdx_d;
      default: acc_q <= acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scale_q      <= vrs_pkg::ScaleReset;
      seed_q       <= vrs_pkg::SeedReset;
      gen_q        <= vrs_pkg::GenReset;
      idx_q        <= '0;
      build_mask_q <= '0;
      built_mask_q <= '0;
      shamt_q      <= '0;
      built_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_a_q      <= '0;
      out_b_q      <= '0;
      out_done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vrs_pkg::CfgScale: scale_q <= cfg_data_i[SW-1:0];
          vrs_pkg::CfgSeed:  seed_q  <= cfg_data_i;
          default:           seed_q  <= seed_q;
        endcase
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (command_i == vrs_pkg::CmdBuild) begin
              gen_q        <= GW'(seed_q);
              idx_q        <= '0;
              build_mask_q <= mask_d;
              shamt_q      <= SW'(31) - eff_scale;
              state_q      <= S_FILL;
            end else begin
              state_q <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          if (out_free) begin
            out_a_q     <= built_q ? vrs_pkg::VertexW'(rd_a_q) : '0;
            out_b_q     <= built_q ? vrs_pkg::VertexW'(rd_b_q) : '0;
            out_done_q  <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_FILL: begin
          if (idx_q == build_mask_q) begin
            idx_q   <= '0;
            state_q <= S_MUL0;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_MUL3;
        S_MUL3: begin
          gen_q   <= {gen_hi_d, acc_q[HW-1:0]};
          state_q <= S_RD;
        end
        S_RD:   state_q <= S_WR1;
        S_WR1:  state_q <= S_WR2;
        S_WR2: begin
          if (idx_q == build_mask_q) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_MUL0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_a_q      <= '0;
            out_b_q      <= '0;
            out_done_q   <= 1'b1;
            out_valid_q  <= 1'b1;
            built_q      <= 1'b1;
            built_mask_q <= build_mask_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && build_done_o |-> (label_a_o == '0) && (label_b_o == '0))
    else $error("build acknowledge carries non-zero labels");

  a_build_starts_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (command_i == vrs_pkg::CmdBuild) |=> state_q == S_FILL)
    else $error("build transfer did not start the fill");

  a_swap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> (jdx_q & ~build_mask_q) == '0)
    else $error("swap index outside the table");

  a_write_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR2 |-> $past(state_q) == S_WR1)
    else $error("second swap write without the first");

endmodule

// ===== tb/sv/vertex_relabel_shuffle_top_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_relabel_shuffle_top_tb: self-checking bench for the relabel shuffle
// Builds permutation tables at several sizes and seeds, then streams relabel
// pairs. Each transfer is predicted in SV (or given a fixed expectation) and
// compared field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module vertex_relabel_shuffle_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems  = 1300;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DirCount   = 22;

  typedef struct packed {
    logic [vrs_pkg::VertexW-1:0] label_a;
    logic [vrs_pkg::VertexW-1:0] label_b;
    logic                        build_done;
  } label_res_t;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic                        cmd;
    logic [vrs_pkg::VertexW-1:0] va;
    logic [vrs_pkg::VertexW-1:0] vb;
    logic                        cfg_idx;
    logic [vrs_pkg::SeedW-1:0]   cfg_data;
    logic                        fixed;
    label_res_t                  want;
  } dir_row_t;

  // fixed expectations only for pre-build relabels and build acknowledgements
  localparam dir_row_t DirRows [DirCount] = '{
    '{RowCfg,  vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowCfg,  vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgSeed,  32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h0000, 16'h0000, vrs_pkg::CfgScale, 32'd0,
      1'b1, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'hFFFF, 16'hFFFF, vrs_pkg::CfgScale, 32'd0,
      1'b1, '0},
    '{RowItem, vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgScale, 32'd0,
      1'b1, '{16'h0, 16'h0, 1'b1}},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h0000, 16'h0001, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'hFFFF, 16'hFFFE, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h8000, 16'h7FFF, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowCfg,  vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgScale, 32'd3,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h0002, 16'h0003, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowCfg,  vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgSeed,  32'hFFFFFFFF,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgScale, 32'd0,
      1'b1, '{16'h0, 16'h0, 1'b1}},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h0000, 16'h0007, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h0005, 16'h0006, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'hFFF8, 16'h000F, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowCfg,  vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgScale, 32'd31,
      1'b0, '0},
    '{RowCfg,  vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgSeed,  32'h5A5AA5A5,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdBuild,   16'h0000, 16'h0000, vrs_pkg::CfgScale, 32'd0,
      1'b1, '{16'h0, 16'h0, 1'b1}},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h0000, 16'hFFFF, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'hAAAA, 16'h5555, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h1234, 16'hFEDC, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0},
    '{RowItem, vrs_pkg::CmdRelabel, 16'h8000, 16'h0001, vrs_pkg::CfgScale, 32'd0,
      1'b0, '0}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic                        cfg_idx_i;
  logic [vrs_pkg::SeedW-1:0]   cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        command_i;
  logic [vrs_pkg::VertexW-1:0] vertex_a_i;
  logic [vrs_pkg::VertexW-1:0] vertex_b_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [vrs_pkg::VertexW-1:0] label_a_o;
  logic [vrs_pkg::VertexW-1:0] label_b_o;
  logic                        build_done_o;

  vertex_relabel_shuffle_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .label_a_o   (label_a_o),
    .label_b_o   (label_b_o),
    .build_done_o(build_done_o)
  );

  // shadow permutation state
  logic [vrs_pkg::ScaleW-1:0]  perm_scale;
  logic [vrs_pkg::SeedW-1:0]   perm_seed;
  logic [vrs_pkg::GenW-1:0]    perm_gen;
  logic [vrs_pkg::VertexW-1:0] perm_map [2**vrs_pkg::AddrBits];
  bit                          perm_built;
  int unsigned                 perm_built_scale;

  label_res_t  label_q [$];
  int unsigned mismatches;
  int unsigned burst_left;
  bit          hold_req;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic label_res_t predict_labels(logic cmd,
                                                logic [vrs_pkg::VertexW-1:0] va,
                                                logic [vrs_pkg::VertexW-1:0] vb);
    label_res_t                   res;
    int unsigned                  s;
    int unsigned                  n;
    int unsigned                  j;
    logic [vrs_pkg::AddrBits-1:0] ix;
    logic [vrs_pkg::AddrBits-1:0] jx;
    logic [vrs_pkg::VertexW-1:0]  tmp;
    logic [30:0]                  draw;
    logic [vrs_pkg::VertexW-1:0]  mask;
    res = '0;
    if (cmd == vrs_pkg::CmdBuild) begin
      s = 32'(perm_scale);
      if (s < 1) s = 1;
      if (s > vrs_pkg::AddrBits) s = vrs_pkg::AddrBits;
      n = 1 << s;
      perm_gen = {32'd0, perm_seed};
      for (int unsigned i = 0; i < n; i++) begin
        ix = i[vrs_pkg::AddrBits-1:0];
        perm_map[ix] = i[vrs_pkg::VertexW-1:0];
      end
      for (int unsigned i = 0; i < n; i++) begin
        perm_gen = perm_gen * vrs_pkg::LcgMul + vrs_pkg::LcgAdd;
        draw = perm_gen[62:32];
        j = {1'b0, draw} >> (31 - s);
        ix = i[vrs_pkg::AddrBits-1:0];
        jx = j[vrs_pkg::AddrBits-1:0];
        tmp = perm_map[ix];
        perm_map[ix] = perm_map[jx];
        perm_map[jx] = tmp;
      end
      perm_built = 1'b1;
      perm_built_scale = s;
      res.build_done = 1'b1;
    end else if (perm_built) begin
      mask = vrs_pkg::VertexW'((32'd1 << perm_built_scale) - 1);
      res.label_a = perm_map[va & mask];
      res.label_b = perm_map[vb & mask];
    end
    return res;
  endfunction

  task automatic write_reg(logic idx, logic [vrs_pkg::SeedW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == vrs_pkg::CfgScale) perm_scale = data[vrs_pkg::ScaleW-1:0];
    else perm_seed = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid and wait until every pending result has been taken
  task automatic settle();
    in_valid_i <= 1'b0;
    while (label_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_item(logic cmd, logic [vrs_pkg::VertexW-1:0] va,
                           logic [vrs_pkg::VertexW-1:0] vb,
                           bit fixed, label_res_t want);
    label_res_t res;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    vertex_a_i <= va;
    vertex_b_i <= vb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = predict_labels(cmd, va, vb);
    label_q.push_back(fixed ? want : res);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    label_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (label_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected transfer: a=%h b=%h done=%b", $realtime,
                   label_a_o, label_b_o, build_done_o);
        mismatches++;
      end else begin
        want = label_q.pop_front();
        if (want.label_a !== label_a_o || want.label_b !== label_b_o ||
            want.build_done !== build_done_o) begin
          if (mismatches < 10)
            $display("[%0t] mismatch: exp a=%h b=%h done=%b, got a=%h b=%h done=%b",
                     $realtime, want.label_a, want.label_b, want.build_done,
                     label_a_o, label_b_o, build_done_o);
          mismatches++;
        end
      end
    end
  end

  // receiver: changing stall patterns plus a long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 200);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (hold_req) begin
          out_ready_i <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: begin
              out_ready_i <= 1'b1;
            end
            1: begin
              out_ready_i <= ($urandom_range(0, 3) != 0);
            end
            2: begin
              out_ready_i <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              out_ready_i <= (k % 3 == 0);
            end
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned                 rand_sent;
    int unsigned                 phase;
    int unsigned                 len;
    int unsigned                 pick;
    logic [vrs_pkg::ScaleW-1:0]  sc;
    logic                        cmd;
    logic [vrs_pkg::VertexW-1:0] va;
    logic [vrs_pkg::VertexW-1:0] vb;
    dir_row_t                    row;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = vrs_pkg::CfgScale;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i  = vrs_pkg::CmdRelabel;
    vertex_a_i = '0;
    vertex_b_i = '0;
    hold_req   = 1'b0;
    burst_left = 0;
    mismatches = 0;
    perm_scale = vrs_pkg::ScaleReset;
    perm_seed  = vrs_pkg::SeedReset;
    perm_gen   = vrs_pkg::GenReset;
    perm_built = 1'b0;
    perm_built_scale = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned r = 0; r < DirCount; r++) begin
      row = DirRows[r];
      if (row.kind == RowCfg) begin
        settle();
        write_reg(row.cfg_idx, row.cfg_data);
      end else begin
        send_item(row.cmd, row.va, row.vb, row.fixed, row.want);
      end
    end

    rand_sent = 0;
    phase = 0;
    while (rand_sent < RandItems) begin
      settle();
      pick = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 7);
      sc = pick[vrs_pkg::ScaleW-1:0];
      write_reg(vrs_pkg::CfgScale, {{(vrs_pkg::SeedW-vrs_pkg::ScaleW){1'b0}}, sc});
      if ($urandom_range(0, 1) != 0) write_reg(vrs_pkg::CfgSeed, $urandom());
      len = $urandom_range(20, 70);
      if (phase == 2 || phase == 15) begin
        hold_req = 1'b1;
        burst_left = 250;
      end
      for (int unsigned k = 0; k < len; k++) begin
        cmd = ((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 39) == 0)
              ? vrs_pkg::CmdBuild : vrs_pkg::CmdRelabel;
        pick = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 15);
        va = pick[vrs_pkg::VertexW-1:0];
        pick = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 15);
        vb = pick[vrs_pkg::VertexW-1:0];
        send_item(cmd, va, vb, 1'b0, '0);
        rand_sent++;
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && label_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
